// File: hw/rtl/lscc_pkg.sv
// ----------------------------------------------------------------------------
// lscc_pkg
// Shared widths, character codes, opcodes and parameter defaults for the
// line sweep cell clear unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lscc_pkg;

  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int COORD_BITS_DEF  = 11;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 12;
  localparam int OP_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [BYTE_W-1:0] SPACE_CODE = 8'd32;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'd57;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/line_sweep_cell_clear_unit.sv
// ----------------------------------------------------------------------------
// line_sweep_cell_clear_unit
// Byte grid with write, read and a Bresenham line sweep that clears digits.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transaction (write, read, sweep), valid/ready.
//   out_* : exactly one result transaction per input transaction.
//   After reset the grid is filled with spaces by a clearing pass over all
//   GRID_WIDTH*GRID_HEIGHT cells (8192 at the defaults); in_ready stays low
//   until it ends.
//   Steps after acceptance: a write, an unused opcode or a read outside the
//   grid goes through EXEC to DONE; a read in the grid goes through EXEC,
//   READ and DONE; a sweep goes through EXEC, SWEEP (once per line point),
//   DRAIN and DONE. The result is registered from DONE, and the next
//   transaction is accepted once the unit is back in IDLE. The sweep loop
//   walks one line point per cycle through the registered-read cell
//   memory, reading the next point while writing back the previous one.
//   One operation is in flight at a time. If the receiver stalls, that
//   result is held in the output register and a finished later result waits
//   internally until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sweep_cell_clear_unit
  import lscc_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [OP_W-1:0]              in_opcode,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  input  wire logic [BYTE_W-1:0]            in_write_byte,

  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [BYTE_W-1:0]                 out_read_byte,
  output logic [COUNT_W-1:0]                out_cleared_count,
  output logic                              out_address_error
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ERR_W  = COORD_BITS + 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic logic in_grid(input logic signed [COORD_BITS-1:0] x,
                                   input logic signed [COORD_BITS-1:0] y);
    logic [31:0] xu;
    logic [31:0] yu;
    xu = 32'($unsigned(x));
    yu = 32'($unsigned(y));
    return !x[COORD_BITS-1] && !y[COORD_BITS-1] &&
           (xu < 32'(GRID_WIDTH)) && (yu < 32'(GRID_HEIGHT));
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic signed [COORD_BITS-1:0] x,
                                                input logic signed [COORD_BITS-1:0] y);
    logic [31:0] xu;
    logic [31:0] yu;
    xu = 32'($unsigned(x));
    yu = 32'($unsigned(y));
    return ADDR_W'(yu * 32'(GRID_WIDTH) + xu);
  endfunction

  // cell memory
  logic [BYTE_W-1:0] mem [CELLS];
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data_r;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;

  state_t                   state_r;
  logic [ADDR_W-1:0]        clr_idx_r;
  logic [OP_W-1:0]          op_r;
  logic signed [COORD_BITS-1:0] x_r, y_r, xe_r, ye_r;
  logic [BYTE_W-1:0]        wbyte_r;
  logic signed [ERR_W-1:0]  dx_r, dy_r, err_r;
  logic                     sx_neg_r, sy_neg_r;
  logic                     pend_r;
  logic [ADDR_W-1:0]        pend_addr_r;
  logic [COUNT_W-1:0]       cnt_r;
  logic [BYTE_W-1:0]        res_byte_r;
  logic                     res_err_r;
  logic                     out_valid_r;
  logic [BYTE_W-1:0]        out_byte_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_err_r;

  logic                     cur_in_grid;
  logic [ADDR_W-1:0]        cur_addr;
  logic                     at_end;
  logic signed [ERR_W-1:0]  e2;
  logic                     step_x, step_y;
  logic signed [ERR_W-1:0]  err_step;
  logic                     is_digit;
  logic                     clr_hit;
  logic [COUNT_W-1:0]       cnt_inc;
  logic signed [ERR_W-1:0]  in_dx, in_dy;

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_byte_r;
  assign out_cleared_count = out_count_r;
  assign out_address_error = out_err_r;

  assign cur_in_grid = in_grid(x_r, y_r);
  assign cur_addr    = addr_of(x_r, y_r);
  assign at_end      = (x_r == xe_r) && (y_r == ye_r);
  assign e2          = err_r <<< 1;
  assign step_x      = (e2 >= dy_r);
  assign step_y      = (e2 <= dx_r);
  assign err_step    = err_r + (step_x ? dy_r : ERR_W'(0)) + (step_y ? dx_r : ERR_W'(0));
  assign is_digit    = mem_rd_data_r inside {[DIGIT_ZERO:DIGIT_NINE]};
  assign clr_hit     = pend_r && is_digit;
  assign cnt_inc     = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);

  // dx is |xe - x|, dy is -|ye - y|
  always_comb begin
    logic signed [ERR_W-1:0] ddx;
    logic signed [ERR_W-1:0] ddy;
    ddx = ERR_W'(in_end_x) - ERR_W'(in_start_x);
    ddy = ERR_W'(in_end_y) - ERR_W'(in_start_y);
    in_dx = ddx[ERR_W-1] ? -ddx : ddx;
    in_dy = ddy[ERR_W-1] ? ddy : -ddy;
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = cur_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_addr;
    mem_wr_data = SPACE_CODE;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx_r;
      end
      ST_EXEC: begin
        if (op_r == OP_WRITE) begin
          mem_wr_en   = cur_in_grid;
          mem_wr_data = wbyte_r;
        end
        if (op_r == OP_READ) begin
          mem_rd_en = cur_in_grid;
        end
      end
      ST_SWEEP, ST_DRAIN: begin
        mem_rd_en   = (state_r == ST_SWEEP) && cur_in_grid;
        mem_wr_en   = clr_hit;
        mem_wr_addr = pend_addr_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_rd_data_r <= mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= res_byte_r;
        out_count_r <= cnt_r;
        out_err_r   <= res_err_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + ADDR_W'(1);
          if (clr_idx_r == ADDR_W'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_r     <= in_opcode;
            x_r      <= in_start_x;
            y_r      <= in_start_y;
            xe_r     <= in_end_x;
            ye_r     <= in_end_y;
            wbyte_r  <= in_write_byte;
            dx_r     <= in_dx;
            dy_r     <= in_dy;
            sx_neg_r <= !(in_start_x < in_end_x);
            sy_neg_r <= !(in_start_y < in_end_y);
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          err_r      <= dx_r + dy_r;
          cnt_r      <= '0;
          res_byte_r <= '0;
          res_err_r  <= (op_r inside {OP_WRITE, OP_READ}) && !cur_in_grid;
          pend_r     <= 1'b0;
          if (op_r == OP_SWEEP) begin
            state_r <= ST_SWEEP;
          end else if ((op_r == OP_READ) && cur_in_grid) begin
            state_r <= ST_READ;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_READ: begin
          res_byte_r <= mem_rd_data_r;
          state_r    <= ST_DONE;
        end
        ST_SWEEP: begin
          // read this point while the previous one is written back
          if (clr_hit) begin
            cnt_r <= cnt_inc;
          end
          pend_r      <= cur_in_grid;
          pend_addr_r <= cur_addr;
          if (at_end) begin
            state_r <= ST_DRAIN;
          end else begin
            err_r <= err_step;
            if (step_x) begin
              x_r <= sx_neg_r ? x_r - COORD_BITS'(1) : x_r + COORD_BITS'(1);
            end
            if (step_y) begin
              y_r <= sy_neg_r ? y_r - COORD_BITS'(1) : y_r + COORD_BITS'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (clr_hit) begin
            cnt_r <= cnt_inc;
          end
          pend_r  <= 1'b0;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a write-back never targets the entry being read in the same cycle
  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("read and write to the same cell in one cycle");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input ready during clearing pass");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EXEC))
    else $error("accepted transaction not executed");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_valid_r && !out_ready) |=>
      ((state_r == ST_DONE) && out_valid_r))
    else $error("result lost while output stalled");

  a_sweep_read_pends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SWEEP) && mem_rd_en) |=> pend_r)
    else $error("sweep read without pending write-back");

endmodule

`default_nettype wire
